### sv/projection_deflation_update_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the projection deflation update block
// ---------------------------------------------------------------------------
`ifndef PROJECTION_DEFLATION_UPDATE_ASSERT_SVH
`define PROJECTION_DEFLATION_UPDATE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// clocked check, off while reset is asserted
`define PDU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define PDU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDU_ASSERT(lbl, prop, msg)
`define PDU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/pdu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdu_pkg
// Shared types and constants of the projection deflation update block.
// ---------------------------------------------------------------------------
package pdu_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_VALUE_WIDTH = 24;

    localparam int ACC_W        = 56;   // dot product accumulator
    localparam int FRAC_W       = 16;   // fraction bits of all values
    localparam int ROW_COUNT_W  = 7;
    localparam int INV_NORM_W   = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 7'd64;
    localparam logic [INV_NORM_W-1:0]  INV_NORM_RESET  = 32'd65536;

    // register word index, paddr[2]
    typedef enum logic
    {
        REG_ROW_COUNT = 1'b0,
        REG_INV_NORM  = 1'b1
    } pdu_reg_t;

    // input beat kind, carried on tuser
    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_BETA = 1'b1
    } pdu_action_t;

    // controller to datapath commands
    typedef struct packed
    {
        logic load_wr;    // write atom/basis pair at load index
        logic beta_wr;    // buffer beta, read atom at row index
        logic dot_mul;    // atom * beta
        logic dot_acc;    // accumulate product
        logic mag_ld;     // accumulator magnitude and sign
        logic coef_lo;    // low partial product with inv_norm
        logic coef_hi;    // high partial product with inv_norm
        logic coef_sum;   // combine, round, saturate; clear accumulator
        logic emit_rd;    // read basis and buffered beta at emit index
        logic emit_mul;   // basis * coefficient
        logic emit_out;   // round, subtract, saturate into output register
        logic emit_last;  // output beat closes the column
    } pdu_cmd_t;

endpackage

### sv/pdu_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdu_ctrl
// Sequencer: input/output handshakes, row and load counters, column end.
// ---------------------------------------------------------------------------
`include "projection_deflation_update_assert.svh"

module pdu_ctrl
    import pdu_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int IDX_W   = $clog2(MAX_ROWS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   action,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [ROW_COUNT_W-1:0] row_count,
    output pdu_cmd_t               cmd,
    output logic [IDX_W-1:0]       load_idx,
    output logic [IDX_W-1:0]       row_idx,
    output logic [IDX_W-1:0]       emit_idx
);

    typedef enum logic [10:0]
    {
        S_IDLE = 11'b000_0000_0001,
        S_MUL  = 11'b000_0000_0010,
        S_ACC  = 11'b000_0000_0100,
        S_MAG  = 11'b000_0000_1000,
        S_LO   = 11'b000_0001_0000,
        S_HI   = 11'b000_0010_0000,
        S_SUM  = 11'b000_0100_0000,
        S_RD   = 11'b000_1000_0000,
        S_TERM = 11'b001_0000_0000,
        S_OUT  = 11'b010_0000_0000,
        S_WAIT = 11'b100_0000_0000
    } state_t;

    localparam logic [ROW_COUNT_W-1:0] ROWS_MAX = ROW_COUNT_W'(MAX_ROWS);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       load_idx_reg, load_idx_next;
    logic [IDX_W-1:0]       row_idx_reg, row_idx_next;
    logic [IDX_W-1:0]       emit_idx_reg, emit_idx_next;
    logic [IDX_W-1:0]       last_k_reg, last_k_next;
    logic                   end_col_reg, end_col_next;
    logic [ROW_COUNT_W-1:0] rows;
    logic                   emit_done;

    // row count clamped to 1..MAX_ROWS
    always_comb
    begin
        if (row_count == '0)
        begin
            rows = ROW_COUNT_W'(1);
        end
        else if (row_count > ROWS_MAX)
        begin
            rows = ROWS_MAX;
        end
        else
        begin
            rows = row_count;
        end
    end

    assign emit_done = (emit_idx_reg == last_k_reg);

    always_comb
    begin
        state_next    = state_reg;
        load_idx_next = load_idx_reg;
        row_idx_next  = row_idx_reg;
        emit_idx_next = emit_idx_reg;
        last_k_next   = last_k_reg;
        end_col_next  = end_col_reg;
        cmd           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (action == ACT_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        if (ROW_COUNT_W'(load_idx_reg) + ROW_COUNT_W'(1) >= rows)
                        begin
                            load_idx_next = '0;
                        end
                        else
                        begin
                            load_idx_next = load_idx_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        cmd.beta_wr  = 1'b1;
                        end_col_next = (ROW_COUNT_W'(row_idx_reg) + ROW_COUNT_W'(1) >= rows);
                        state_next   = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.dot_mul = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.dot_acc = 1'b1;
                if (end_col_reg)
                begin
                    last_k_next   = row_idx_reg;
                    emit_idx_next = '0;
                    state_next    = S_MAG;
                end
                else
                begin
                    row_idx_next = row_idx_reg + IDX_W'(1);
                    state_next   = S_IDLE;
                end
            end
            S_MAG:
            begin
                cmd.mag_ld = 1'b1;
                state_next = S_LO;
            end
            S_LO:
            begin
                cmd.coef_lo = 1'b1;
                state_next  = S_HI;
            end
            S_HI:
            begin
                cmd.coef_hi = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.coef_sum = 1'b1;
                row_idx_next = '0;
                state_next   = S_RD;
            end
            S_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_TERM;
            end
            S_TERM:
            begin
                cmd.emit_mul = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit_out  = 1'b1;
                cmd.emit_last = emit_done;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (m_tready)
                begin
                    if (emit_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_idx_reg <= '0;
            row_idx_reg  <= '0;
            emit_idx_reg <= '0;
            last_k_reg   <= '0;
            end_col_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_idx_reg <= load_idx_next;
            row_idx_reg  <= row_idx_next;
            emit_idx_reg <= emit_idx_next;
            last_k_reg   <= last_k_next;
            end_col_reg  <= end_col_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_WAIT);
    assign load_idx = load_idx_reg;
    assign row_idx  = row_idx_reg;
    assign emit_idx = emit_idx_reg;

    `PDU_ASSERT_ALWAYS(a_no_in_out_overlap, !(s_tready && m_tvalid), "input and output open together")
    `PDU_ASSERT(a_emit_in_column, emit_idx_reg <= last_k_reg, "emit index past column end")
    `PDU_ASSERT(a_last_beat_idle, (m_tvalid && m_tready && emit_done) |=> s_tready, "no idle after last beat")
    `PDU_ASSERT(a_load_in_range, 32'(load_idx_reg) < MAX_ROWS, "load index out of range")

endmodule

### sv/pdu_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdu_datapath
// Vector stores, column buffer, dot product, coefficient and output math.
// ---------------------------------------------------------------------------
module pdu_datapath
    import pdu_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int IDX_W      = $clog2(MAX_ROWS)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdu_cmd_t                      cmd,
    input  logic [IDX_W-1:0]              load_idx,
    input  logic [IDX_W-1:0]              row_idx,
    input  logic [IDX_W-1:0]              emit_idx,
    input  logic [INV_NORM_W-1:0]         inv_norm,
    input  logic signed [VALUE_WIDTH-1:0] atom_value,
    input  logic signed [VALUE_WIDTH-1:0] basis_value,
    input  logic signed [VALUE_WIDTH-1:0] beta_value,
    output logic [VALUE_WIDTH-1:0]        updated_value,
    output logic                          last_of_column
);

    localparam int VW     = VALUE_WIDTH;
    localparam int CW     = 62 - VALUE_WIDTH;        // coefficient width
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int P_W    = VALUE_WIDTH + CW;        // basis * coefficient
    localparam int TERM_W = P_W + 1 - FRAC_W;
    localparam int DIFF_W = TERM_W + 1;
    localparam int Q_W    = 57;
    localparam int MUL_W  = 32;

    localparam logic [Q_W-1:0] COEF_LIM = Q_W'(1) << (CW - 1);
    localparam logic signed [DIFF_W-1:0] V_HI = {{(DIFF_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] V_LO = {{(DIFF_W-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [P_W:0] RND_POS = (P_W+1)'(32768);
    localparam logic signed [P_W:0] RND_NEG = (P_W+1)'(32767);

    logic signed [VW-1:0] atom_mem  [MAX_ROWS];
    logic signed [VW-1:0] basis_mem [MAX_ROWS];
    logic signed [VW-1:0] col_mem   [MAX_ROWS];

    logic signed [VW-1:0]     atom_rd_reg;
    logic signed [VW-1:0]     beta_reg;
    logic signed [VW-1:0]     basis_rd_reg;
    logic signed [VW-1:0]     col_rd_reg;
    logic signed [VW-1:0]     col_dly_reg;
    logic signed [PROD_W-1:0] dot_prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [2*MUL_W-1:0]       lo_reg;
    logic [2*MUL_W-1:0]       hi_reg;
    logic signed [CW-1:0]     coef_reg;
    logic signed [P_W-1:0]    term_prod_reg;
    logic [VW-1:0]            out_data_reg;
    logic                     out_last_reg;

    logic [MUL_W-1:0]         mul_a;
    logic [2*MUL_W-1:0]       mul_p;
    logic [Q_W-1:0]           q_sum;
    logic [Q_W-1:0]           q_cap;
    logic [Q_W-1:0]           q_sat;
    logic signed [CW-1:0]     coef_next;
    logic signed [P_W:0]      p_rnd;
    logic signed [TERM_W-1:0] term;
    logic signed [DIFF_W-1:0] diff;
    logic [VW-1:0]            out_next;

    // vector stores and column buffer
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            atom_mem[load_idx]  <= atom_value;
            basis_mem[load_idx] <= basis_value;
        end
        if (cmd.beta_wr)
        begin
            col_mem[row_idx] <= beta_value;
            atom_rd_reg      <= atom_mem[row_idx];
        end
        if (cmd.emit_rd)
        begin
            basis_rd_reg <= basis_mem[emit_idx];
            col_rd_reg   <= col_mem[emit_idx];
        end
    end

    // one 32x32 multiplier for both halves of the magnitude
    assign mul_a = cmd.coef_hi ? MUL_W'(mag_reg[ACC_W-1:MUL_W]) : mag_reg[MUL_W-1:0];
    assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(inv_norm);

    // round to nearest (ties away) via bit 31 of the low product
    assign q_sum = hi_reg[Q_W-1:0] + Q_W'(lo_reg[2*MUL_W-1:MUL_W]) + Q_W'(lo_reg[MUL_W-1]);
    assign q_cap = neg_reg ? COEF_LIM : (COEF_LIM - Q_W'(1));
    assign q_sat = (q_sum > q_cap) ? q_sum & '0 | q_cap : q_sum;
    assign coef_next = neg_reg ? -CW'(q_sat) : CW'(q_sat);

    // term = round(basis * coef / 2^16), ties away from zero
    assign p_rnd = (P_W+1)'(term_prod_reg) + (term_prod_reg[P_W-1] ? RND_NEG : RND_POS);
    assign term  = p_rnd[P_W:FRAC_W];
    assign diff  = DIFF_W'(col_dly_reg) - DIFF_W'(term);

    always_comb
    begin
        if (diff > V_HI)
        begin
            out_next = VW'(V_HI);
        end
        else if (diff < V_LO)
        begin
            out_next = VW'(V_LO);
        end
        else
        begin
            out_next = VW'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.beta_wr)
        begin
            beta_reg <= beta_value;
        end
        if (cmd.dot_mul)
        begin
            dot_prod_reg <= atom_rd_reg * beta_reg;
        end
        if (cmd.mag_ld)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
        end
        if (cmd.coef_lo)
        begin
            lo_reg <= mul_p;
        end
        if (cmd.coef_hi)
        begin
            hi_reg <= mul_p;
        end
        if (cmd.coef_sum)
        begin
            coef_reg <= coef_next;
        end
        if (cmd.emit_mul)
        begin
            term_prod_reg <= basis_rd_reg * coef_reg;
            col_dly_reg   <= col_rd_reg;
        end
        if (cmd.emit_out)
        begin
            out_data_reg <= out_next;
            out_last_reg <= cmd.emit_last;
        end
    end

    // accumulator wraps at 56 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.coef_sum)
        begin
            acc_reg <= '0;
        end
        else if (cmd.dot_acc)
        begin
            acc_reg <= acc_reg + ACC_W'(dot_prod_reg);
        end
    end

    assign updated_value  = out_data_reg;
    assign last_of_column = out_last_reg;

endmodule

### sv/projection_deflation_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// projection_deflation_update
// Rank-one deflation of beta columns: beta - basis * ((atom . beta) * inv_norm).
// ---------------------------------------------------------------------------
// Input stream (s_*): tuser = 0 loads one atom/basis pair into the next load
// slot and leaves the input ready; tuser = 1 gives one beta element, column-major.
// A beta beat goes through store read, multiply and accumulate. When a
// column's last row arrives, the coefficient is formed (magnitude,
// two 32x32 partial products against inv_norm, round/saturate), then the
// column is sent on m_* one beat per row, tlast on the final row.
// Each output beat goes through store read, multiply, round/saturate and
// handshake, and waits while m_tready stays low; the output is held stable
// and no input is taken while a column drains.
// Reset sets row_count to 64, inv_norm to 1.0 and clears the row and load
// counters and the accumulator; vector contents are undefined until loaded.
// Config over APB: row_count at 0x0, inv_norm at 0x4; write only while idle.
// ---------------------------------------------------------------------------
module projection_deflation_update
    import pdu_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int IN_W       = ((3 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((VALUE_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // atom_value, basis_value, beta_value
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // updated_value
    output logic                  m_tlast,   // last_of_column
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam int VW    = VALUE_WIDTH;

    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [INV_NORM_W-1:0]  inv_norm_reg;
    logic                   cfg_wr;
    pdu_cmd_t               cmd;
    logic [IDX_W-1:0]       load_idx;
    logic [IDX_W-1:0]       row_idx;
    logic [IDX_W-1:0]       emit_idx;
    logic [VW-1:0]          updated_value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RESET;
            inv_norm_reg  <= INV_NORM_RESET;
        end
        else if (cfg_wr)
        begin
            case (pdu_reg_t'(paddr[2]))
                REG_ROW_COUNT: row_count_reg <= pwdata[ROW_COUNT_W-1:0];
                REG_INV_NORM:  inv_norm_reg  <= pwdata[INV_NORM_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (pdu_reg_t'(paddr[2]))
            REG_ROW_COUNT: prdata = CFG_DATA_W'(row_count_reg);
            REG_INV_NORM:  prdata = CFG_DATA_W'(inv_norm_reg);
            default:       prdata = '0;
        endcase
    end

    pdu_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .row_count (row_count_reg),
        .cmd       (cmd),
        .load_idx  (load_idx),
        .row_idx   (row_idx),
        .emit_idx  (emit_idx)
    );

    pdu_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .load_idx       (load_idx),
        .row_idx        (row_idx),
        .emit_idx       (emit_idx),
        .inv_norm       (inv_norm_reg),
        .atom_value     (s_tdata[VW-1:0]),
        .basis_value    (s_tdata[2*VW-1:VW]),
        .beta_value     (s_tdata[3*VW-1:2*VW]),
        .updated_value  (updated_value),
        .last_of_column (m_tlast)
    );

    assign m_tdata = OUT_W'(updated_value);

endmodule

### tb/deflation_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deflation_checker
// Watches the input stream, the APB writes and the output stream of the
// projection deflation block. It keeps its own copy of the vectors, the
// column buffer, the dot product and the registers, predicts every updated
// column element and compares each output beat with the oldest prediction.
// ---------------------------------------------------------------------------
module deflation_checker
    import pdu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [((3*DEF_VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // atom, basis, beta
    input  logic                        s_tuser,   // action
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [DEF_VALUE_WIDTH-1:0]  m_tdata,   // updated_value
    input  logic                        m_tlast,   // last_of_column
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [CFG_ADDR_W-1:0]       paddr,
    input  logic [CFG_DATA_W-1:0]       pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          open_updates
);

    localparam int VW     = DEF_VALUE_WIDTH;
    localparam int ROWS   = DEF_MAX_ROWS;
    localparam int IN_W   = ((3 * VW + 7) / 8) * 8;
    localparam int COEF_W = 62 - VW;
    localparam longint VAL_MAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;

    typedef struct packed
    {
        logic [VW-1:0] value;
        logic          last_flag;
    } column_beat_t;

    logic signed [VW-1:0]   atom_mem  [ROWS];
    logic signed [VW-1:0]   basis_mem [ROWS];
    logic signed [VW-1:0]   beta_buf  [ROWS];
    int unsigned            load_slot;
    int unsigned            row_slot;
    logic [ACC_W-1:0]       dot_sum;
    logic [ROW_COUNT_W-1:0] rows_reg;
    logic [INV_NORM_W-1:0]  inv_norm_reg;
    column_beat_t           expected_updates [$];

    function automatic int unsigned active_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > ROWS)
            return ROWS;
        return 32'(rows_reg);
    endfunction

    // dot * inv_norm / 2^32, rounded half away from zero, saturated to Q.16
    function automatic longint coefficient(input logic [ACC_W-1:0] acc,
                                           input logic [INV_NORM_W-1:0] scale);
        logic [ACC_W-1:0] mag;
        logic [87:0]      prod;
        logic [87:0]      q;
        logic [87:0]      lim;
        mag  = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
        prod = {32'd0, mag} * {56'd0, scale};
        q    = (prod + (88'd1 << 31)) >> 32;
        lim  = 88'd1 << (COEF_W - 1);
        if (acc[ACC_W-1])
        begin
            if (q > lim)
                q = lim;
            return -longint'(q[63:0]);
        end
        if (q > lim - 1)
            q = lim - 1;
        return longint'(q[63:0]);
    endfunction

    function automatic longint round_q16(input longint a);
        if (a < 0)
            return -((-a + 32768) >>> 16);
        return (a + 32768) >>> 16;
    endfunction

    function automatic logic [VW-1:0] clamp_value(input longint v);
        if (v > VAL_MAX)
            return VAL_MAX[VW-1:0];
        if (v < VAL_MIN)
            return VAL_MIN[VW-1:0];
        return v[VW-1:0];
    endfunction

    function automatic void deflate_beat(input logic [IN_W-1:0] data, input logic action);
        int unsigned          rows;
        int unsigned          r;
        int unsigned          n;
        logic signed [VW-1:0] b;
        longint               prod;
        longint               coef;
        longint               term;
        column_beat_t         beat;
        rows = active_rows();
        if (action == ACT_LOAD)
        begin
            r = load_slot % ROWS;
            atom_mem[r]  = data[VW-1:0];
            basis_mem[r] = data[2*VW-1:VW];
            load_slot    = (r + 1 >= rows) ? 0 : r + 1;
        end
        else
        begin
            r = row_slot % ROWS;
            b = data[3*VW-1:2*VW];
            beta_buf[r] = b;
            prod    = longint'(atom_mem[r]) * longint'(b);
            dot_sum = dot_sum + prod[ACC_W-1:0];
            if (r + 1 < rows)
                row_slot = r + 1;
            else
            begin
                // column closes here, also when row_count shrank below the index
                coef = coefficient(dot_sum, inv_norm_reg);
                n    = r + 1;
                for (int k = 0; k < n; k++)
                begin
                    term = round_q16(longint'(basis_mem[k]) * coef);
                    beat.value     = clamp_value(longint'(beta_buf[k]) - term);
                    beat.last_flag = (k + 1 == n);
                    expected_updates.push_back(beat);
                end
                row_slot = 0;
                dot_sum  = '0;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        column_beat_t want;
        if (!rst_n)
        begin
            load_slot    = 0;
            row_slot     = 0;
            dot_sum      = '0;
            rows_reg     = ROW_COUNT_RESET;
            inv_norm_reg = INV_NORM_RESET;
            expected_updates.delete();
            mismatches   = 0;
            open_updates = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_updates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: updated_value %0d last %0b",
                                 $signed(m_tdata), m_tlast);
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last_flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: updated_value %0d expected %0d, last %0b expected %0b",
                                     $signed(m_tdata), $signed(want.value),
                                     m_tlast, want.last_flag);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_ROW_COUNT: rows_reg     = pwdata[ROW_COUNT_W-1:0];
                    REG_INV_NORM:  inv_norm_reg = pwdata[INV_NORM_W-1:0];
                    default:       rows_reg     = rows_reg;
                endcase
            end
            if (s_tvalid && s_tready)
                deflate_beat(s_tdata, s_tuser);
            open_updates = expected_updates.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the projection deflation block: fills the atom and basis
// vectors, runs directed columns over the corner cases, then random columns
// under several row counts, scale factors and handshake idling patterns.
// ---------------------------------------------------------------------------
module tb
    import pdu_pkg::*;
();

    localparam int VW             = DEF_VALUE_WIDTH;
    localparam int IN_W           = ((3 * VW + 7) / 8) * 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;

    localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] ONE_Q16 = VW'(32'h0001_0000);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;   // atom_value, basis_value, beta_value
    logic                  s_tuser;   // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [VW-1:0]         m_tdata;   // updated_value
    logic                  m_tlast;   // last_of_column
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int open_updates;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles = 0;

    int phase_rows  [PHASES] = '{1, 3, 64, 5, 127, 0, 16, 2};
    int phase_items [PHASES] = '{24, 30, 52, 30, 52, 20, 32, 30};

    projection_deflation_update dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    deflation_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .open_updates (open_updates)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL projection_deflation_update");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [VW-1:0] rand_value();
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return VW'($urandom_range(8191)) - VW'(4096);
            4, 5:    return VW'($urandom_range(262143)) - VW'(131072);
            default: return VW'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_norm();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'd0;
            2, 3:    return 32'd65536 + 32'($urandom_range(65535)) - 32'd32768;
            default: return 32'($urandom) >> $urandom_range(31);
        endcase
    endfunction

    // mode 0: no idling, 1: sender, 2: receiver, 3: both lightly
    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 76;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 76;
            end
            default:
            begin
                sender_idle_pct    = 27;
                receiver_stall_pct = 27;
            end
        endcase
    endtask

    task automatic push_beat(input pdu_action_t act, input logic [VW-1:0] atom,
                             input logic [VW-1:0] basis, input logic [VW-1:0] beta);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {beta, basis, atom};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic load_pair(input logic [VW-1:0] atom, input logic [VW-1:0] basis);
        push_beat(ACT_LOAD, atom, basis, rand_value());
    endtask

    task automatic feed_beta(input logic [VW-1:0] beta);
        push_beat(ACT_BETA, rand_value(), rand_value(), beta);
    endtask

    // hold the input until every predicted beat is out and the pipeline is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_updates != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pdu_reg_t which, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= ACT_LOAD;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        set_idling(0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every vector slot at the reset row count of 64
        load_pair(VAL_MAX, VAL_MIN);
        load_pair(VAL_MIN, VAL_MAX);
        for (int i = 2; i < DEF_MAX_ROWS; i++)
            load_pair(rand_value(), rand_value());
        drain();

        write_reg(REG_ROW_COUNT, 32'd2);
        write_reg(REG_INV_NORM, 32'd65536);
        load_pair(VAL_MAX, VAL_MIN);
        load_pair(VAL_MIN, VAL_MAX);
        load_pair(ONE_Q16, ONE_Q16);        // wraps back onto slot 0
        feed_beta(ONE_Q16);
        feed_beta(VW'(32'h0002_0000));
        feed_beta(VAL_MAX);
        feed_beta(VAL_MIN);
        load_pair(VAL_MAX, VAL_MAX);
        feed_beta(VAL_MIN);
        load_pair(VAL_MIN, VAL_MIN);        // basis changes before the column ends
        feed_beta(VAL_MIN);
        feed_beta('0);
        feed_beta('0);
        drain();

        // coefficient saturates in both directions
        write_reg(REG_INV_NORM, 32'hFFFF_FFFF);
        feed_beta(VAL_MIN);
        feed_beta(VAL_MAX);
        feed_beta(VAL_MAX);
        feed_beta(VAL_MIN);
        drain();

        // row count 0 behaves as a single row, zero scale
        write_reg(REG_ROW_COUNT, 32'd0);
        write_reg(REG_INV_NORM, 32'd0);
        feed_beta(VAL_MIN);
        feed_beta(VAL_MAX);
        load_pair(VW'(32'h0000_8000), VW'(32'h0001_8000));
        feed_beta(VAL_MAX);
        drain();

        // row count shrinks under a half-finished column
        write_reg(REG_ROW_COUNT, 32'd8);
        write_reg(REG_INV_NORM, 32'd65536);
        repeat (5) feed_beta(rand_value());
        drain();
        write_reg(REG_ROW_COUNT, 32'd3);
        feed_beta(rand_value());
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_ROW_COUNT, 32'(phase_rows[p]));
            write_reg(REG_INV_NORM, rand_norm());
            set_idling(p % 4);
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (p % 2 == 1 && k == phase_items[p] / 2)
                    drain();
                if ($urandom_range(99) < 15)
                    load_pair(rand_value(), rand_value());
                else
                    feed_beta(rand_value());
            end
            drain();
        end

        if (mismatches == 0 && open_updates == 0)
            $display("PASS projection_deflation_update");
        else
            $display("FAIL projection_deflation_update");
        $finish;
    end

endmodule
